// ----- src/cfla_pkg.sv -----
// Package for the coalescing free-list allocator.
// Holds the widths, request and status codes and the controller/datapath structs.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package cfla_pkg;

  // Table depth and region addressing.
  localparam int TABLE_DEPTH = 16;
  localparam int OFFSET_BITS = 16;

  localparam int OFF_W = OFFSET_BITS;
  localparam int SIZE_W = OFFSET_BITS + 1;
  localparam int END_W = SIZE_W + 1;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ACC_W = SIZE_W + IDX_W;

  localparam logic [SIZE_W-1:0] REGION_MAX = SIZE_W'(1) << OFFSET_BITS;
  localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  // Request types.
  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NOP   = 2'd3
  } req_type_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_FULL   = 2'd2,
    ST_ZERO   = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    req_load;
    logic    idx_clr;
    logic    idx_inc;
    logic    i_clr;
    logic    i_inc;
    logic    rd_sel_i;
    logic    fit_clr;
    logic    fit_step;
    logic    merge_latch;
    logic    merge_do;
    logic    merged_set;
    logic    alloc_do;
    logic    insert_do;
    logic    region_load;
    logic    sum_clr;
    logic    sum_step;
    logic    res_load;
    logic    status_we;
    status_e status;
  } cfla_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_type_e req_type;
    logic      req_zero;
    logic      idx_last;
    logic      i_last;
    logic      entry_valid;
    logic      merge_match;
    logic      best_found;
    logic      has_empty;
    logic      merged;
    logic      out_free;
  } cfla_sts_t;

endpackage

`default_nettype wire

// ----- src/cfla_ifs.sv -----
// Channel interfaces of the allocator: request, response and configuration.
// Depends on cfla_pkg for the field widths.
`default_nettype none

interface cfla_req_if
  import cfla_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [SIZE_W-1:0] req_size;
  logic [OFF_W-1:0]  free_offset;

  modport source (output valid, req_type, req_size, free_offset, input ready);
  modport sink (input valid, req_type, req_size, free_offset, output ready);
endinterface

interface cfla_rsp_if
  import cfla_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OFF_W-1:0]  granted_offset;
  logic [1:0]        status;
  logic [SIZE_W-1:0] allocated_bytes;
  logic [SIZE_W-1:0] free_bytes;

  modport source (output valid, granted_offset, status, allocated_bytes, free_bytes,
                  input ready);
  modport sink (input valid, granted_offset, status, allocated_bytes, free_bytes,
                output ready);
endinterface

interface cfla_cfg_if
  import cfla_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] region_size;

  modport source (output valid, region_size, input ready);
  modport sink (input valid, region_size, output ready);
endinterface

`default_nettype wire

// ----- src/coalescing_free_list_allocator.sv -----
// Top level of the coalescing best-fit free-list allocator.
// Depends on cfla_pkg, cfla_ifs, cfla_ctrl and cfla_dp.
//
//   Channel  | Direction | Payload
//   req_i    | in        | req_type, req_size, free_offset
//   rsp_o    | out       | granted_offset, status, allocated_bytes, free_bytes
//   cfg_i    | in        | region_size (takes effect on the next clear)
//
// A no-op or zero-size item passes through acceptance, decode, a free-byte sum over the
// single table read port, and the output load before the next acceptance. A free adds
// the table insert, a clear the region load, an allocate the best-fit scan, its check
// and the table update. A merge pass scans the table once per valid entry and
// restarts after each merge found. Reset loads the whole region as one free block; a
// result waits in the output register while the next item is accepted, and a stalled
// output holds the block only once the following result is ready.
`default_nettype none

module coalescing_free_list_allocator
  import cfla_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  cfla_req_if.sink   req_i,
  cfla_rsp_if.source rsp_o,
  cfla_cfg_if.sink   cfg_i
);

  cfla_cmd_t cmd;
  cfla_sts_t sts;

  // Controller.
  cfla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath.
  cfla_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_type_i    (req_i.req_type),
    .req_size_i    (req_i.req_size),
    .free_offset_i (req_i.free_offset),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rsp           (rsp_o),
    .cfg           (cfg_i)
  );

`ifndef ASSERT_OFF
  // The block works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while busy");

  // A failed or non-allocate result grants offset zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != ST_OK)) |-> (rsp_o.granted_offset == '0))
    else $error("granted offset on failed request");

  // Byte counts stay within the region.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> ((rsp_o.free_bytes <= REGION_MAX) &&
                     (rsp_o.allocated_bytes <= REGION_MAX)))
    else $error("byte count beyond region");
`endif

endmodule

`default_nettype wire

// ----- src/cfla_ctrl.sv -----
// Controller state machine of the allocator: sequences fit scans, merge passes,
// table updates and the free-byte sum. Depends on cfla_pkg.
`default_nettype none

module cfla_ctrl
  import cfla_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  cfla_sts_t sts_i,
  output cfla_cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_DECODE  = 11'b000_0000_0010,
    S_FIT     = 11'b000_0000_0100,
    S_FIT_END = 11'b000_0000_1000,
    S_MERGE_I = 11'b000_0001_0000,
    S_MERGE_J = 11'b000_0010_0000,
    S_ALLOC   = 11'b000_0100_0000,
    S_INSERT  = 11'b000_1000_0000,
    S_LOAD    = 11'b001_0000_0000,
    S_SUM     = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.status = ST_OK;
    req_ready_o = 1'b0;
    unique case (state_q) inside
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.req_type) inside
          REQ_ALLOC, REQ_FREE: begin
            if (sts_i.req_zero) begin
              cmd_o.status_we = 1'b1;
              cmd_o.status = ST_ZERO;
              cmd_o.sum_clr = 1'b1;
              cmd_o.idx_clr = 1'b1;
              state_d = S_SUM;
            end else if (sts_i.req_type == REQ_ALLOC) begin
              cmd_o.fit_clr = 1'b1;
              cmd_o.idx_clr = 1'b1;
              state_d = S_FIT;
            end else if (sts_i.has_empty) begin
              state_d = S_INSERT;
            end else if (sts_i.merged) begin
              cmd_o.status_we = 1'b1;
              cmd_o.status = ST_FULL;
              cmd_o.sum_clr = 1'b1;
              cmd_o.idx_clr = 1'b1;
              state_d = S_SUM;
            end else begin
              cmd_o.i_clr = 1'b1;
              state_d = S_MERGE_I;
            end
          end
          REQ_CLEAR: state_d = S_LOAD;
          default: begin
            cmd_o.sum_clr = 1'b1;
            cmd_o.idx_clr = 1'b1;
            state_d = S_SUM;
          end
        endcase
      end
      S_FIT: begin
        cmd_o.fit_step = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_FIT_END;
        end
      end
      S_FIT_END: begin
        if (sts_i.best_found) begin
          state_d = S_ALLOC;
        end else if (sts_i.merged) begin
          cmd_o.status_we = 1'b1;
          cmd_o.status = ST_NO_FIT;
          cmd_o.sum_clr = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d = S_SUM;
        end else begin
          cmd_o.i_clr = 1'b1;
          state_d = S_MERGE_I;
        end
      end
      S_MERGE_I: begin
        cmd_o.rd_sel_i = 1'b1;
        if (sts_i.entry_valid) begin
          cmd_o.merge_latch = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d = S_MERGE_J;
        end else if (sts_i.i_last) begin
          cmd_o.merged_set = 1'b1;
          state_d = S_DECODE;
        end else begin
          cmd_o.i_inc = 1'b1;
        end
      end
      S_MERGE_J: begin
        if (sts_i.merge_match) begin
          // A merge restarts the pass from the first entry.
          cmd_o.merge_do = 1'b1;
          cmd_o.i_clr = 1'b1;
          state_d = S_MERGE_I;
        end else if (sts_i.idx_last) begin
          if (sts_i.i_last) begin
            cmd_o.merged_set = 1'b1;
            state_d = S_DECODE;
          end else begin
            cmd_o.i_inc = 1'b1;
            state_d = S_MERGE_I;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_ALLOC, S_INSERT, S_LOAD: begin
        cmd_o.alloc_do = (state_q == S_ALLOC);
        cmd_o.insert_do = (state_q == S_INSERT);
        cmd_o.region_load = (state_q == S_LOAD);
        cmd_o.sum_clr = 1'b1;
        cmd_o.idx_clr = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum_step = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/cfla_dp.sv -----
// Datapath of the allocator: free table, scan counters, best-fit and merge
// registers, counters and the response register. Depends on cfla_pkg, cfla_ifs.
`default_nettype none

module cfla_dp
  import cfla_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        req_type_i,
  input  logic [SIZE_W-1:0] req_size_i,
  input  logic [OFF_W-1:0]  free_offset_i,
  input  cfla_cmd_t         cmd_i,
  output cfla_sts_t         sts_o,
  cfla_rsp_if.source        rsp,
  cfla_cfg_if.sink          cfg
);

  // Free table.
  logic [OFF_W-1:0]       off_q [TABLE_DEPTH];
  logic [SIZE_W-1:0]      size_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;

  // Request and working registers.
  logic [1:0]        req_type_q;
  logic [SIZE_W-1:0] req_size_q;
  logic [OFF_W-1:0]  free_offset_q;
  logic [IDX_W-1:0]  idx_q, i_q, best_idx_q;
  logic              best_found_q, merged_q;
  logic [SIZE_W-1:0] best_size_q, cur_size_q, region_q, alloc_q;
  logic [OFF_W-1:0]  best_off_q, grant_q;
  logic [END_W-1:0]  cur_end_q;
  logic [ACC_W-1:0]  acc_q;
  status_e           status_q;

  // Response register.
  logic              out_valid_q;
  logic [OFF_W-1:0]  out_grant_q;
  status_e           out_status_q;
  logic [SIZE_W-1:0] out_alloc_q, out_free_q;

  logic [IDX_W-1:0]  rd_idx, empty_idx;
  logic [OFF_W-1:0]  rd_off;
  logic [SIZE_W-1:0] rd_size, region_sat, merged_size, free_sum;
  logic              rd_valid, has_empty, fit_better;
  logic [SIZE_W:0]   merge_raw, alloc_add;

  // One read port, addressed by the merge outer index or the scan index.
  assign rd_idx = cmd_i.rd_sel_i ? i_q : idx_q;
  assign rd_off = off_q[rd_idx];
  assign rd_size = size_q[rd_idx];
  assign rd_valid = valid_q[rd_idx];

  // Lowest free slot.
  always_comb begin
    has_empty = 1'b0;
    empty_idx = '0;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      if (!valid_q[k]) begin
        has_empty = 1'b1;
        empty_idx = IDX_W'(k);
      end
    end
  end

  assign region_sat = (region_q > REGION_MAX) ? REGION_MAX : region_q;
  assign merge_raw = {1'b0, cur_size_q} + {1'b0, rd_size};
  assign merged_size = merge_raw[SIZE_W] ? SIZE_SAT : merge_raw[SIZE_W-1:0];
  assign alloc_add = {1'b0, alloc_q} + {1'b0, req_size_q};
  assign free_sum = (acc_q > ACC_W'(REGION_MAX)) ? REGION_MAX : acc_q[SIZE_W-1:0];

  // A candidate beats the current best on size, then on offset.
  assign fit_better = rd_valid && (rd_size >= req_size_q) &&
                      (!best_found_q || (rd_size < best_size_q) ||
                       ((rd_size == best_size_q) && (rd_off < best_off_q)));

  // Status to the controller.
  always_comb begin
    sts_o.req_type = req_type_e'(req_type_q);
    sts_o.req_zero = (req_size_q == '0);
    sts_o.idx_last = (idx_q == IDX_LAST);
    sts_o.i_last = (i_q == IDX_LAST);
    sts_o.entry_valid = rd_valid;
    sts_o.merge_match = (idx_q != i_q) && rd_valid && ({2'b00, rd_off} == cur_end_q);
    sts_o.best_found = best_found_q;
    sts_o.has_empty = has_empty;
    sts_o.merged = merged_q;
    sts_o.out_free = !out_valid_q || rsp.ready;
  end

  // Free table updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        off_q[k] <= '0;
        size_q[k] <= (k == 0) ? REGION_MAX : '0;
      end
      valid_q <= TABLE_DEPTH'(1);
    end else if (cmd_i.region_load) begin
      off_q[0] <= '0;
      size_q[0] <= region_sat;
      valid_q <= TABLE_DEPTH'(region_sat != '0);
    end else if (cmd_i.merge_do) begin
      size_q[i_q] <= merged_size;
      valid_q[idx_q] <= 1'b0;
    end else if (cmd_i.alloc_do) begin
      if (best_size_q > req_size_q) begin
        off_q[best_idx_q] <= best_off_q + req_size_q[OFF_W-1:0];
        size_q[best_idx_q] <= best_size_q - req_size_q;
      end else begin
        valid_q[best_idx_q] <= 1'b0;
      end
    end else if (cmd_i.insert_do) begin
      off_q[empty_idx] <= free_offset_q;
      size_q[empty_idx] <= req_size_q;
      valid_q[empty_idx] <= 1'b1;
    end
  end

  // Control registers: counters, flags, byte count and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      i_q <= '0;
      best_found_q <= 1'b0;
      merged_q <= 1'b0;
      alloc_q <= '0;
      region_q <= REGION_MAX;
      status_q <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg.valid) begin
        region_q <= cfg.region_size;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc && (idx_q != IDX_LAST)) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.i_clr) begin
        i_q <= '0;
      end else if (cmd_i.i_inc) begin
        i_q <= i_q + IDX_W'(1);
      end
      if (cmd_i.req_load) begin
        merged_q <= 1'b0;
        status_q <= ST_OK;
      end else begin
        if (cmd_i.merged_set) begin
          merged_q <= 1'b1;
        end
        if (cmd_i.status_we) begin
          status_q <= cmd_i.status;
        end
      end
      if (cmd_i.fit_clr) begin
        best_found_q <= 1'b0;
      end else if (cmd_i.fit_step && fit_better) begin
        best_found_q <= 1'b1;
      end
      if (cmd_i.region_load) begin
        alloc_q <= '0;
      end else if (cmd_i.alloc_do) begin
        alloc_q <= (alloc_add > {1'b0, REGION_MAX}) ? REGION_MAX : alloc_add[SIZE_W-1:0];
      end else if (cmd_i.insert_do) begin
        alloc_q <= (alloc_q > req_size_q) ? (alloc_q - req_size_q) : '0;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_type_q <= req_type_i;
      req_size_q <= req_size_i;
      free_offset_q <= free_offset_i;
      grant_q <= '0;
    end else if (cmd_i.alloc_do) begin
      grant_q <= best_off_q;
    end
    if (cmd_i.fit_step && fit_better) begin
      best_idx_q <= idx_q;
      best_size_q <= rd_size;
      best_off_q <= rd_off;
    end
    if (cmd_i.merge_latch) begin
      cur_size_q <= rd_size;
      cur_end_q <= {2'b00, rd_off} + {1'b0, rd_size};
    end
    if (cmd_i.sum_clr) begin
      acc_q <= '0;
    end else if (cmd_i.sum_step && rd_valid) begin
      acc_q <= acc_q + ACC_W'(rd_size);
    end
    if (cmd_i.res_load) begin
      out_grant_q <= grant_q;
      out_status_q <= status_q;
      out_alloc_q <= alloc_q;
      out_free_q <= free_sum;
    end
  end

  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid_q;
  assign rsp.granted_offset = out_grant_q;
  assign rsp.status = out_status_q;
  assign rsp.allocated_bytes = out_alloc_q;
  assign rsp.free_bytes = out_free_q;

endmodule

`default_nettype wire
